// File: rtl/core/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Parser mode codes, control character codes and shared types for the
// escape sequence stripper.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned CodeW = 16;
    localparam int unsigned ModeW = 3;

    typedef logic [CodeW-1:0] t_code;
    typedef logic [ModeW-1:0] t_mode;

    localparam t_mode MODE_PLAIN   = 3'd0;
    localparam t_mode MODE_START   = 3'd1;
    localparam t_mode MODE_CSI     = 3'd2;
    localparam t_mode MODE_SEQ     = 3'd3;
    localparam t_mode MODE_STRING  = 3'd4;
    localparam t_mode MODE_STR_ESC = 3'd5;

    localparam t_code CH_BEL        = 16'd7;
    localparam t_code CH_ESC        = 16'd27;
    localparam t_code CH_CSI1       = 16'd155;
    localparam t_code CH_LBRACKET   = 16'd91;
    localparam t_code CH_P          = 16'd80;
    localparam t_code CH_RBRACKET   = 16'd93;
    localparam t_code CH_CARET      = 16'd94;
    localparam t_code CH_UNDERSCORE = 16'd95;
    localparam t_code CH_AT         = 16'd64;
    localparam t_code CH_TILDE      = 16'd126;
    localparam t_code CH_BACKSLASH  = 16'd92;

    typedef struct packed {
        logic  load;
        logic  keep;
        t_code code;
    } t_result;

endpackage

// File: rtl/core/aes_parse.sv
// ----------------------------------------------------------------------------
// aes_parse
// Holds the parser mode and decides for each code unit whether it is kept.
// ----------------------------------------------------------------------------
module aes_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  aes_pkg::t_code i_code,
    output logic          o_keep
);
    import aes_pkg::*;

    t_mode r_mode;
    t_mode n_mode;
    logic  keep;

    always_comb begin
        n_mode = r_mode;
        keep   = 1'b0;
        unique case (r_mode)
            MODE_START: begin
                priority if (i_code == CH_LBRACKET) begin
                    n_mode = MODE_CSI;
                end else if (i_code == CH_P || i_code == CH_RBRACKET ||
                             i_code == CH_CARET || i_code == CH_UNDERSCORE) begin
                    n_mode = MODE_STRING;
                end else if (i_code >= CH_AT && i_code <= CH_UNDERSCORE) begin
                    n_mode = MODE_PLAIN;
                end else begin
                    n_mode = MODE_SEQ;
                end
            end
            MODE_CSI: begin
                if (i_code >= CH_AT && i_code <= CH_TILDE) begin
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_SEQ: begin
                if (i_code >= CH_AT && i_code <= CH_UNDERSCORE) begin
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_STRING: begin
                priority if (i_code == CH_BEL) begin
                    n_mode = MODE_PLAIN;
                end else if (i_code == CH_ESC) begin
                    n_mode = MODE_STR_ESC;
                end else begin
                    n_mode = MODE_STRING;
                end
            end
            MODE_STR_ESC: begin
                n_mode = (i_code == CH_BACKSLASH) ? MODE_PLAIN : MODE_STRING;
            end
            default: begin
                priority if (i_code == CH_ESC) begin
                    n_mode = MODE_START;
                end else if (i_code == CH_CSI1) begin
                    n_mode = MODE_CSI;
                end else begin
                    n_mode = MODE_PLAIN;
                    keep   = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
        end else if (i_fire) begin
            r_mode <= n_mode;
        end
    end

    assign o_keep = keep;

endmodule

// File: rtl/core/aes_out_reg.sv
// ----------------------------------------------------------------------------
// aes_out_reg
// Result register: holds a kept character until the output transfer.
// ----------------------------------------------------------------------------
module aes_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  aes_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output aes_pkg::t_code   o_kept_char
);
    import aes_pkg::*;

    logic  r_valid;
    t_code r_char;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.load && i_res.keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.load && i_res.keep) begin
            r_char <= i_res.code;
        end
    end

    assign o_valid     = r_valid;
    assign o_kept_char = r_char;

endmodule

// File: rtl/core/ansi_escape_stripper.sv
// ----------------------------------------------------------------------------
// ansi_escape_stripper
// Removes ANSI escape sequences from a stream of 16-bit code units.
// ----------------------------------------------------------------------------
// One code unit is taken per clock unless the output side stalls. Each unit is
// held in the input register, where the parser mode decides whether it is
// kept, and kept units are then loaded into the result register, which drives
// the output: one unit per cycle sustained while the receiver is ready. Units
// inside an escape sequence, including its opening and closing units, produce
// no output; the parser mode carries across lines.
module ansi_escape_stripper (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  aes_pkg::t_code i_code_unit,
    output logic           o_valid,
    input  logic           i_ready,
    output aes_pkg::t_code o_kept_char
);
    import aes_pkg::*;

    logic    r_in_valid;
    t_code   r_in_code;
    logic    out_free;
    logic    fire;
    logic    keep;
    t_result res;

    assign fire    = r_in_valid && out_free;
    assign o_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_code <= i_code_unit;
        end
    end

    aes_parse u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (fire),
        .i_code (r_in_code),
        .o_keep (keep)
    );

    assign res.load = fire;
    assign res.keep = keep;
    assign res.code = r_in_code;

    aes_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .o_free     (out_free),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kept_char(o_kept_char)
    );

endmodule

// File: rtl/core/aes_checker.sv
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks for the escape sequence stripper, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input aes_pkg::t_code i_code_unit,
    input logic           o_valid,
    input logic           i_ready,
    input aes_pkg::t_code o_kept_char
);
    import aes_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_code_unit))
        else $error("input transfer dropped or changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kept_char))
        else $error("output transfer dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while the output side can move");

    a_no_escape_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kept_char != CH_ESC && o_kept_char != CH_CSI1)
        else $error("escape introducer passed through");

endmodule

bind ansi_escape_stripper aes_checker u_aes_checker (.*);

// File: bench/ansi_escape_stripper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_stripper_tb
// Self-checking bench for the escape sequence stripper. A directed table
// walks plain text, the extreme code units and each kind of escape. Random
// traffic follows, made mostly of well-formed CSI, string, generic and short
// escapes with random content, mixed with plain runs and raw noise. Kept units
// are predicted per transfer and compared in order, with random idle gaps on
// both sides.
// ----------------------------------------------------------------------------
module ansi_escape_stripper_tb;
    import aes_pkg::*;

    localparam int unsigned RandomUnits = 1250;
    localparam int unsigned IdleLimit   = 4000;
    localparam int unsigned ShowLimit   = 40;

    typedef struct packed {
        t_code cu;
        bit    fixed;
        bit    fixed_keep;
        t_code fixed_char;
    } t_row;

    localparam int unsigned DirRows = 24;
    localparam t_row DIRECTED [0:DirRows-1] = '{
        '{16'h0041,      1'b1, 1'b1, 16'h0041},
        '{16'h0000,      1'b1, 1'b1, 16'h0000},
        '{16'hffff,      1'b1, 1'b1, 16'hffff},
        '{CH_ESC,        1'b1, 1'b0, 16'h0000},
        '{CH_LBRACKET,   1'b0, 1'b0, 16'h0000},
        '{16'h0141,      1'b0, 1'b0, 16'h0000},
        '{16'h006d,      1'b0, 1'b0, 16'h0000},
        '{CH_CSI1,       1'b1, 1'b0, 16'h0000},
        '{CH_TILDE,      1'b0, 1'b0, 16'h0000},
        '{CH_ESC,        1'b0, 1'b0, 16'h0000},
        '{CH_P,          1'b0, 1'b0, 16'h0000},
        '{CH_BEL,        1'b0, 1'b0, 16'h0000},
        '{CH_ESC,        1'b0, 1'b0, 16'h0000},
        '{CH_CARET,      1'b0, 1'b0, 16'h0000},
        '{CH_ESC,        1'b0, 1'b0, 16'h0000},
        '{16'h0071,      1'b0, 1'b0, 16'h0000},
        '{CH_ESC,        1'b0, 1'b0, 16'h0000},
        '{CH_BACKSLASH,  1'b0, 1'b0, 16'h0000},
        '{CH_ESC,        1'b0, 1'b0, 16'h0000},
        '{CH_AT,         1'b0, 1'b0, 16'h0000},
        '{CH_ESC,        1'b0, 1'b0, 16'h0000},
        '{16'h0028,      1'b0, 1'b0, 16'h0000},
        '{16'h0042,      1'b0, 1'b0, 16'h0000},
        '{16'h007a,      1'b0, 1'b0, 16'h0000}
    };

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_valid     = 1'b0;
    logic  o_ready;
    t_code i_code_unit = '0;
    logic  o_valid;
    logic  i_ready     = 1'b0;
    t_code o_kept_char;

    t_mode       esc_mode = MODE_PLAIN;
    t_code       pending_kept [$];
    t_row        unit_stream [$];
    bit          steady = 1'b0;
    int unsigned error_count = 0;
    int unsigned n_kept = 0, n_dropped = 0, n_checked = 0;
    int unsigned n_csi = 0, n_string = 0, n_generic = 0, n_short = 0, n_noise = 0;

    ansi_escape_stripper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_unit (i_code_unit),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kept_char (o_kept_char)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Advance the parser by one code unit; return whether the unit is kept.
    function automatic bit advance_parser(input t_code cu);
        bit keep;
        keep = 1'b0;
        case (esc_mode)
            MODE_START: begin
                if (cu == CH_LBRACKET)
                    esc_mode = MODE_CSI;
                else if (cu == CH_P || cu == CH_RBRACKET || cu == CH_CARET ||
                         cu == CH_UNDERSCORE)
                    esc_mode = MODE_STRING;
                else if (cu >= CH_AT && cu <= CH_UNDERSCORE)
                    esc_mode = MODE_PLAIN;
                else
                    esc_mode = MODE_SEQ;
            end
            MODE_CSI: begin
                if (cu >= CH_AT && cu <= CH_TILDE)
                    esc_mode = MODE_PLAIN;
            end
            MODE_SEQ: begin
                if (cu >= CH_AT && cu <= CH_UNDERSCORE)
                    esc_mode = MODE_PLAIN;
            end
            MODE_STRING: begin
                if (cu == CH_BEL)
                    esc_mode = MODE_PLAIN;
                else if (cu == CH_ESC)
                    esc_mode = MODE_STR_ESC;
            end
            MODE_STR_ESC: begin
                esc_mode = (cu == CH_BACKSLASH) ? MODE_PLAIN : MODE_STRING;
            end
            default: begin
                if (cu == CH_ESC) begin
                    esc_mode = MODE_START;
                end else if (cu == CH_CSI1) begin
                    esc_mode = MODE_CSI;
                end else begin
                    esc_mode = MODE_PLAIN;
                    keep = 1'b1;
                end
            end
        endcase
        return keep;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void push_unit(input t_code cu);
        unit_stream.push_back('{cu, 1'b0, 1'b0, 16'h0000});
    endfunction

    function automatic t_code text_unit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return t_code'($urandom_range(32, 126));
        return t_code'($urandom_range(256, 65535));
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= ShowLimit)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Alternate stretches with and without idling.
    initial begin
        forever begin
            repeat ($urandom_range(100, 600)) @(posedge i_clk);
            steady <= ($urandom_range(0, 3) == 0);
        end
    end

    // Receiver: check each transfer, then stall at random.
    initial begin
        int unsigned stall_left;
        t_code       want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                n_checked++;
                if (pending_kept.size() == 0) begin
                    report_mismatch($sformatf("kept_char 0x%04h with nothing expected",
                                              o_kept_char));
                end else begin
                    want = pending_kept.pop_front();
                    if (o_kept_char !== want)
                        report_mismatch($sformatf("kept_char 0x%04h, expected 0x%04h",
                                                  o_kept_char, want));
                end
            end
            if (stall_left != 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IdleLimit, pending_kept.size());
                $display("ansi_escape_stripper_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int unsigned idx, len, kind, send_gap, drain_a, drain_b;
        t_code       c;
        t_row        row;

        for (int i = 0; i < DirRows; i++)
            unit_stream.push_back(DIRECTED[i]);

        while (unit_stream.size() < DirRows + RandomUnits) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                len = $urandom_range(1, 8);
                repeat (len) push_unit(text_unit());
            end else if (kind < 50) begin
                n_csi++;
                if ($urandom_range(0, 3) == 0) begin
                    push_unit(CH_CSI1);
                end else begin
                    push_unit(CH_ESC);
                    push_unit(CH_LBRACKET);
                end
                len = $urandom_range(0, 6);
                repeat (len) begin
                    case ($urandom_range(0, 9))
                        0:       push_unit(t_code'($urandom_range(256, 65535)));
                        1:       push_unit(t_code'($urandom_range(0, 31)));
                        2:       push_unit(t_code'($urandom_range(32, 47)));
                        default: push_unit(t_code'($urandom_range(48, 63)));
                    endcase
                end
                push_unit(t_code'($urandom_range(64, 126)));
            end else if (kind < 68) begin
                n_string++;
                push_unit(CH_ESC);
                case ($urandom_range(0, 3))
                    0:       push_unit(CH_P);
                    1:       push_unit(CH_RBRACKET);
                    2:       push_unit(CH_CARET);
                    default: push_unit(CH_UNDERSCORE);
                endcase
                len = $urandom_range(0, 8);
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) begin
                        do c = t_code'($urandom_range(32, 126)); while (c == CH_BACKSLASH);
                        push_unit(CH_ESC);
                        push_unit(c);
                    end else begin
                        push_unit(text_unit());
                    end
                end
                if ($urandom_range(0, 1) == 0) begin
                    push_unit(CH_BEL);
                end else begin
                    push_unit(CH_ESC);
                    push_unit(CH_BACKSLASH);
                end
            end else if (kind < 78) begin
                n_generic++;
                push_unit(CH_ESC);
                case ($urandom_range(0, 3))
                    0:       push_unit(t_code'($urandom_range(96, 126)));
                    1:       push_unit(t_code'($urandom_range(256, 65535)));
                    default: push_unit(t_code'($urandom_range(32, 63)));
                endcase
                len = $urandom_range(0, 3);
                repeat (len) push_unit(t_code'($urandom_range(32, 63)));
                push_unit(t_code'($urandom_range(64, 95)));
            end else if (kind < 86) begin
                n_short++;
                push_unit(CH_ESC);
                do c = t_code'($urandom_range(64, 95));
                while (c == CH_P || c == CH_LBRACKET || c == CH_RBRACKET ||
                       c == CH_CARET || c == CH_UNDERSCORE);
                push_unit(c);
            end else begin
                n_noise++;
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 1) == 0)
                        push_unit(t_code'($urandom_range(0, 65535)));
                    else
                        push_unit(t_code'($urandom_range(0, 255)));
                end
            end
        end

        drain_a = DirRows;
        drain_b = $urandom_range(DirRows + 200, DirRows + 1000);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender: hold the payload until transfer, pause at the drain points.
        idx = 0;
        send_gap = 0;
        while (idx < unit_stream.size()) begin
            @(posedge i_clk);
            if (i_valid && o_ready) begin
                row = unit_stream[idx];
                if (advance_parser(row.cu)) begin
                    n_kept++;
                    if (!row.fixed)
                        pending_kept.push_back(row.cu);
                end else begin
                    n_dropped++;
                end
                if (row.fixed && row.fixed_keep)
                    pending_kept.push_back(row.fixed_char);
                idx++;
            end
            if (!i_valid || o_ready) begin
                if (idx == unit_stream.size()) begin
                    i_valid <= 1'b0;
                end else if (send_gap != 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if ((idx == drain_a || idx == drain_b) && pending_kept.size() != 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid     <= 1'b1;
                    i_code_unit <= unit_stream[idx].cu;
                    send_gap    = pick_gap();
                end
            end
        end

        while (pending_kept.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("summary: %0d units sent, %0d kept, %0d dropped, %0d outputs checked",
                 unit_stream.size(), n_kept, n_dropped, n_checked);
        $display("summary: %0d CSI, %0d string, %0d generic, %0d short escapes, %0d noise runs",
                 n_csi, n_string, n_generic, n_short, n_noise);
        if (error_count == 0) begin
            $display("ansi_escape_stripper_tb: clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("ansi_escape_stripper_tb: errors");
        end
        $finish;
    end

endmodule
